// ----- hw/rtl/spring_deadband_velocity_loop_macros.svh -----
// Assertion macros for the spring deadband velocity loop.
`ifndef SPRING_DEADBAND_VELOCITY_LOOP_MACROS_SVH
`define SPRING_DEADBAND_VELOCITY_LOOP_MACROS_SVH
`ifndef SYNTHESIS
`define SDVL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sdvl check failed");
`define SDVL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sdvl check failed");
`else
`define SDVL_ASSERT_NOW(label, ante, cons)
`define SDVL_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- hw/rtl/sdvl_pkg.sv -----
// Shared types, constants and coefficient table of the velocity loop.
`default_nettype none
package sdvl_pkg;

  localparam int NCOEF     = 11;
  localparam int MUL_A_W   = 18;
  localparam int MUL_B_W   = 32;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int ACC_W     = 48;
  localparam int CFG_IDX_W = 3;
  localparam int GAIN_SH   = 15;
  localparam int FIR_SH    = 15;
  localparam int OUT_SH    = 23;

  localparam logic [1:0] MODE_VEL = 2'd1;
  localparam logic [1:0] MODE_TRQ = 2'd2;

  localparam logic [11:0] COEF [NCOEF] = '{
    12'd2055, 12'd1963, 12'd2618, 12'd3175, 12'd3549, 12'd3680,
    12'd3549, 12'd3175, 12'd2618, 12'd1963, 12'd2055
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE      = 3'd0,
    CFG_BAND_LOW  = 3'd1,
    CFG_BAND_HIGH = 3'd2,
    CFG_VEL_TGT   = 3'd3,
    CFG_PROP_GAIN = 3'd4,
    CFG_DAMP_GAIN = 3'd5,
    CFG_FF_GAIN   = 3'd6,
    CFG_POS_LIM   = 3'd7
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_FIRD, S_FDRN, S_DEFL, S_FIRL, S_LDRN, S_GAINP, S_GAIND,
    S_GAINF, S_GDRN, S_SCALE, S_RATIO, S_RDRN, S_SAT, S_LIMIT
  } state_t;

  typedef struct packed {
    logic issue;
    logic shift;
    logic clear;
  } mac_ctl_t;

  // Q1.15 tap; taps past the table are zero.
  function automatic logic signed [MUL_A_W-1:0] fir_coef(input logic [4:0] idx);
    logic signed [MUL_A_W-1:0] c;
    c = '0;
    if (idx < 5'(NCOEF)) begin
      c = $signed({{(MUL_A_W-12){1'b0}}, COEF[idx[3:0]]});
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/sdvl_in_if.sv -----
// Tick input channel: valid/ready plus sensor payload.
`default_nettype none
interface sdvl_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] spring_deflection;
  logic signed [15:0] spring_velocity;
  logic signed [15:0] load_velocity;
  logic        [15:0] load_position;
  logic               link_timeout;

  modport source (output valid, output spring_deflection, output spring_velocity,
                  output load_velocity, output load_position, output link_timeout,
                  input ready);
  modport sink   (input valid, input spring_deflection, input spring_velocity,
                  input load_velocity, input load_position, input link_timeout,
                  output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/sdvl_out_if.sv -----
// Command result channel: valid/ready plus command payload.
`default_nettype none
interface sdvl_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] velocity_command;
  logic               limit_zeroed;
  logic               timeout_zeroed;

  modport source (output valid, output velocity_command, output limit_zeroed,
                  output timeout_zeroed, input ready);
  modport sink   (input valid, input velocity_command, input limit_zeroed,
                  input timeout_zeroed, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/sdvl_cfg_if.sv -----
// Register write channel: valid/ready plus index and data.
`default_nettype none
interface sdvl_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [sdvl_pkg::CFG_IDX_W-1:0]   index;
  logic [31:0]                      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/sdvl_mac.sv -----
// Shared multiply-accumulate unit: registered product, then accumulate.
`default_nettype none
module sdvl_mac (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire sdvl_pkg::mac_ctl_t                    ctl,
  input  wire logic signed [sdvl_pkg::MUL_A_W-1:0]   mul_a,
  input  wire logic signed [sdvl_pkg::MUL_B_W-1:0]   mul_b,
  output logic signed [sdvl_pkg::ACC_W-1:0]          acc
);

  logic signed [sdvl_pkg::PROD_W-1:0] prod_full;
  logic signed [sdvl_pkg::ACC_W-1:0]  prod_r;
  logic                               pvld_r;
  logic                               pshift_r;
  logic signed [sdvl_pkg::ACC_W-1:0]  addend;
  logic signed [sdvl_pkg::ACC_W-1:0]  acc_r;

  assign prod_full = mul_a * mul_b;
  assign addend    = pshift_r ? (prod_r <<< sdvl_pkg::GAIN_SH) : prod_r;
  assign acc       = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvld_r   <= 1'b0;
      pshift_r <= 1'b0;
    end else begin
      pvld_r   <= ctl.issue;
      pshift_r <= ctl.shift;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_full[sdvl_pkg::ACC_W-1:0];
    if (ctl.clear) begin
      acc_r <= '0;
    end else if (pvld_r) begin
      acc_r <= acc_r + addend;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/spring_deadband_velocity_loop.sv -----
// Top level of the decimated series-elastic velocity loop.
//
//   channel | dir | payload                                           | beat when
//   in_if   | in  | deflection, spring vel, load vel, position, t/o   | valid & ready
//   out_if  | out | velocity_command, limit_zeroed, timeout_zeroed    | valid & ready
//   cfg_if  | in  | index (3b), data (32b)                            | valid & ready
//
// A tick that emits nothing only shifts the delay lines and tick phase. An emitting
// tick in torque mode runs its steps through the single shared
// 18x32 multiplier that runs both filters, the three gains and the ratio.
// Other modes go straight to the limit step. Reset (rst_n low, synchronous) clears
// the delay lines, tick phase, configuration registers, sequencer and result valid flag.
// A held result stalls only the final step; a new tick is accepted while the last result waits.
`default_nettype none
`include "spring_deadband_velocity_loop_macros.svh"
module spring_deadband_velocity_loop #(
  parameter int          TAPS         = 11,
  parameter int unsigned HALF_TURN    = 32768,
  parameter int unsigned OUTPUT_RATIO = 1,
  parameter int          DECIMATION   = 5
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  sdvl_in_if.sink     in_if,
  sdvl_out_if.source  out_if,
  sdvl_cfg_if.sink    cfg_if
);

  localparam int IDX_W = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam logic signed [sdvl_pkg::MUL_A_W-1:0] RATIO_OP =
    sdvl_pkg::MUL_A_W'(OUTPUT_RATIO);
  localparam logic signed [sdvl_pkg::ACC_W-1:0] FIR_BIAS =
    sdvl_pkg::ACC_W'((1 << sdvl_pkg::FIR_SH) - 1);
  localparam logic signed [sdvl_pkg::ACC_W-1:0] OUT_BIAS =
    sdvl_pkg::ACC_W'((1 << sdvl_pkg::OUT_SH) - 1);
  localparam logic signed [sdvl_pkg::ACC_W-1:0] ACC_ZERO = '0;
  localparam logic signed [sdvl_pkg::ACC_W-1:0] SAT_MAX =
    sdvl_pkg::ACC_W'(64'sd2147483647);
  localparam logic signed [sdvl_pkg::ACC_W-1:0] SAT_MIN =
    sdvl_pkg::ACC_W'(-64'sd2147483648);

  // configuration registers
  logic        [1:0]  mode_r;
  logic signed [15:0] band_low_r;
  logic signed [15:0] band_high_r;
  logic signed [31:0] vel_tgt_r;
  logic signed [15:0] prop_gain_r;
  logic signed [15:0] damp_gain_r;
  logic signed [15:0] ff_gain_r;
  logic        [31:0] pos_lim_r;

  // tick state
  logic signed [15:0] dline_r [TAPS];
  logic signed [15:0] lline_r [TAPS];
  logic        [4:0]  phase_r;
  logic        [4:0]  phase_nxt;
  logic               emit;
  logic               in_beat;

  // sequencer and datapath
  sdvl_pkg::state_t   state_r;
  sdvl_pkg::state_t   state_nxt;
  logic [IDX_W-1:0]   idx_r;
  logic               idx_last;
  logic signed [15:0] sv_r;
  logic        [15:0] pos_r;
  logic               tmo_r;
  logic signed [16:0] f_r;
  logic signed [17:0] delta_r;
  logic signed [31:0] lv_r;
  logic signed [31:0] q_r;
  logic signed [31:0] cmd_r;

  logic                                   out_valid_r;
  logic signed [31:0]                     out_cmd_r;
  logic                                   out_lim_r;
  logic                                   out_tmo_r;
  logic                                   out_load;

  sdvl_pkg::mac_ctl_t                     mac_ctl;
  logic signed [sdvl_pkg::MUL_A_W-1:0]    mul_a;
  logic signed [sdvl_pkg::MUL_B_W-1:0]    mul_b;
  logic signed [sdvl_pkg::ACC_W-1:0]      acc;
  logic signed [sdvl_pkg::ACC_W-1:0]      acc_fir;
  logic signed [sdvl_pkg::ACC_W-1:0]      acc_out;
  logic signed [16:0]                     band_low_x;
  logic signed [16:0]                     band_high_x;
  logic signed [17:0]                     delta_nxt;
  logic signed [16:0]                     neg_sv;
  logic                                   fwd_hit;
  logic                                   rev_hit;
  logic                                   lim_hit;

  // ---------------- configuration ----------------
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= '0;
      band_low_r  <= '0;
      band_high_r <= '0;
      vel_tgt_r   <= '0;
      prop_gain_r <= '0;
      damp_gain_r <= '0;
      ff_gain_r   <= '0;
      pos_lim_r   <= '0;
    end else if (cfg_if.valid) begin
      unique case (sdvl_pkg::cfg_idx_t'(cfg_if.index))
        sdvl_pkg::CFG_MODE:      mode_r      <= cfg_if.data[1:0];
        sdvl_pkg::CFG_BAND_LOW:  band_low_r  <= cfg_if.data[15:0];
        sdvl_pkg::CFG_BAND_HIGH: band_high_r <= cfg_if.data[15:0];
        sdvl_pkg::CFG_VEL_TGT:   vel_tgt_r   <= cfg_if.data;
        sdvl_pkg::CFG_PROP_GAIN: prop_gain_r <= cfg_if.data[15:0];
        sdvl_pkg::CFG_DAMP_GAIN: damp_gain_r <= cfg_if.data[15:0];
        sdvl_pkg::CFG_FF_GAIN:   ff_gain_r   <= cfg_if.data[15:0];
        sdvl_pkg::CFG_POS_LIM:   pos_lim_r   <= cfg_if.data;
      endcase
    end
  end

  // ---------------- tick intake ----------------
  assign in_if.ready = (state_r == sdvl_pkg::S_IDLE);
  assign in_beat     = in_if.valid && in_if.ready;
  assign phase_nxt   = phase_r + 5'd1;
  assign emit        = (phase_nxt >= 5'(DECIMATION));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      for (int i = 0; i < TAPS; i++) begin
        dline_r[i] <= '0;
        lline_r[i] <= '0;
      end
    end else if (in_beat) begin
      phase_r    <= emit ? 5'd0 : phase_nxt;
      dline_r[0] <= in_if.spring_deflection;
      lline_r[0] <= in_if.load_velocity;
      for (int i = 1; i < TAPS; i++) begin
        dline_r[i] <= dline_r[i-1];
        lline_r[i] <= lline_r[i-1];
      end
    end
  end

  // ---------------- sequencer ----------------
  assign idx_last = (idx_r == IDX_W'(TAPS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sdvl_pkg::S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == sdvl_pkg::S_FIRD || state_r == sdvl_pkg::S_FIRL) begin
        idx_r <= idx_last ? '0 : idx_r + IDX_W'(1);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sdvl_pkg::S_IDLE: begin
        if (in_beat && emit) begin
          state_nxt = (mode_r == sdvl_pkg::MODE_TRQ) ? sdvl_pkg::S_FIRD
                                                     : sdvl_pkg::S_LIMIT;
        end
      end
      sdvl_pkg::S_FIRD:  if (idx_last) state_nxt = sdvl_pkg::S_FDRN;
      sdvl_pkg::S_FDRN:  state_nxt = sdvl_pkg::S_DEFL;
      sdvl_pkg::S_DEFL:  state_nxt = sdvl_pkg::S_FIRL;
      sdvl_pkg::S_FIRL:  if (idx_last) state_nxt = sdvl_pkg::S_LDRN;
      sdvl_pkg::S_LDRN:  state_nxt = sdvl_pkg::S_GAINP;
      sdvl_pkg::S_GAINP: state_nxt = sdvl_pkg::S_GAIND;
      sdvl_pkg::S_GAIND: state_nxt = sdvl_pkg::S_GAINF;
      sdvl_pkg::S_GAINF: state_nxt = sdvl_pkg::S_GDRN;
      sdvl_pkg::S_GDRN:  state_nxt = sdvl_pkg::S_SCALE;
      sdvl_pkg::S_SCALE: state_nxt = sdvl_pkg::S_RATIO;
      sdvl_pkg::S_RATIO: state_nxt = sdvl_pkg::S_RDRN;
      sdvl_pkg::S_RDRN:  state_nxt = sdvl_pkg::S_SAT;
      sdvl_pkg::S_SAT:   state_nxt = sdvl_pkg::S_LIMIT;
      sdvl_pkg::S_LIMIT: if (out_load) state_nxt = sdvl_pkg::S_IDLE;
      default:           state_nxt = sdvl_pkg::S_IDLE;
    endcase
  end

  // operand select and MAC control per step
  assign neg_sv = -$signed({sv_r[15], sv_r});

  always_comb begin
    mac_ctl = '0;
    mul_a   = '0;
    mul_b   = '0;
    unique case (state_r)
      sdvl_pkg::S_IDLE, sdvl_pkg::S_DEFL, sdvl_pkg::S_SCALE: begin
        mac_ctl.clear = 1'b1;
      end
      sdvl_pkg::S_FIRD: begin
        mac_ctl.issue = 1'b1;
        mul_a = sdvl_pkg::fir_coef(5'(idx_r));
        mul_b = sdvl_pkg::MUL_B_W'(dline_r[idx_r]);
      end
      sdvl_pkg::S_FIRL: begin
        mac_ctl.issue = 1'b1;
        mul_a = sdvl_pkg::fir_coef(5'(idx_r));
        mul_b = sdvl_pkg::MUL_B_W'(lline_r[idx_r]);
      end
      sdvl_pkg::S_GAINP: begin
        // lv_r takes the settled load sum in this same step
        mac_ctl.clear = 1'b1;
        mac_ctl.issue = 1'b1;
        mac_ctl.shift = 1'b1;
        mul_a = sdvl_pkg::MUL_A_W'(prop_gain_r);
        mul_b = sdvl_pkg::MUL_B_W'(delta_r);
      end
      sdvl_pkg::S_GAIND: begin
        mac_ctl.issue = 1'b1;
        mac_ctl.shift = 1'b1;
        mul_a = sdvl_pkg::MUL_A_W'(damp_gain_r);
        mul_b = sdvl_pkg::MUL_B_W'(neg_sv);
      end
      sdvl_pkg::S_GAINF: begin
        mac_ctl.issue = 1'b1;
        mul_a = sdvl_pkg::MUL_A_W'(ff_gain_r);
        mul_b = lv_r;
      end
      sdvl_pkg::S_RATIO: begin
        mac_ctl.issue = 1'b1;
        mul_a = RATIO_OP;
        mul_b = q_r;
      end
      default: begin
        mac_ctl = '0;
      end
    endcase
  end

  sdvl_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .acc   (acc)
  );

  // ---------------- datapath ----------------
  // truncate toward zero: bias negative sums before the shift
  assign acc_fir = (acc + (acc[sdvl_pkg::ACC_W-1] ? FIR_BIAS : ACC_ZERO)) >>> sdvl_pkg::FIR_SH;
  assign acc_out = (acc + (acc[sdvl_pkg::ACC_W-1] ? OUT_BIAS : ACC_ZERO)) >>> sdvl_pkg::OUT_SH;

  assign band_low_x  = {band_low_r[15], band_low_r};
  assign band_high_x = {band_high_r[15], band_high_r};

  always_comb begin
    if (band_low_x > f_r) begin
      delta_nxt = 18'(band_low_x) - 18'(f_r);
    end else if (band_high_x < f_r) begin
      delta_nxt = 18'(band_high_x) - 18'(f_r);
    end else begin
      delta_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      sv_r  <= in_if.spring_velocity;
      pos_r <= in_if.load_position;
      tmo_r <= in_if.link_timeout;
      cmd_r <= (mode_r == sdvl_pkg::MODE_VEL) ? vel_tgt_r : 32'sd0;
    end
    unique case (state_r)
      sdvl_pkg::S_DEFL:  f_r     <= acc_fir[16:0];
      sdvl_pkg::S_FIRL:  delta_r <= delta_nxt;
      sdvl_pkg::S_GAINP: lv_r    <= acc[31:0];
      sdvl_pkg::S_SCALE: q_r     <= acc_out[31:0];
      sdvl_pkg::S_SAT: begin
        if (acc > SAT_MAX) begin
          cmd_r <= SAT_MAX[31:0];
        end else if (acc < SAT_MIN) begin
          cmd_r <= SAT_MIN[31:0];
        end else begin
          cmd_r <= acc[31:0];
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------- limits and result register ----------------
  assign fwd_hit = (pos_r > pos_lim_r[31:16]) && ({16'd0, pos_r} < 32'(HALF_TURN))
                && !cmd_r[31] && (cmd_r != 32'sd0);
  assign rev_hit = (pos_r < pos_lim_r[15:0]) && ({16'd0, pos_r} > 32'(HALF_TURN))
                && cmd_r[31];
  assign lim_hit = fwd_hit || rev_hit;

  assign out_load = (state_r == sdvl_pkg::S_LIMIT) && (!out_valid_r || out_if.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_cmd_r <= (lim_hit || tmo_r) ? 32'sd0 : cmd_r;
      out_lim_r <= lim_hit;
      out_tmo_r <= tmo_r;
    end
  end

  assign out_if.valid            = out_valid_r;
  assign out_if.velocity_command = out_cmd_r;
  assign out_if.limit_zeroed     = out_lim_r;
  assign out_if.timeout_zeroed   = out_tmo_r;

  // ---------------- checks ----------------
  `SDVL_ASSERT_NOW(a_phase_range, 1'b1, phase_r < 5'(DECIMATION))
  `SDVL_ASSERT_NOW(a_tmo_zero, out_valid_r && out_tmo_r, out_cmd_r == 32'sd0)
  `SDVL_ASSERT_NOW(a_lim_zero, out_valid_r && out_lim_r, out_cmd_r == 32'sd0)
  `SDVL_ASSERT_NEXT(a_result_shown, out_load, out_valid_r && state_r == sdvl_pkg::S_IDLE)

endmodule
`default_nettype wire
